[rtl/scd_pkg.sv]
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package scd_pkg;

	// Default frame store depth
	localparam int MAX_FRAME_DEF = 16;

	// Header layout
	localparam int SUM_START  = 2;  // first byte covered by the checksum
	localparam int LEN_IDX    = 3;  // length byte
	localparam int SUM_IDX    = 4;  // checksum byte
	localparam int LEN_OFFSET = 4;  // total length = length byte + offset

	// Field widths
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 4;
	localparam int FLEN_W = 5;
	localparam int SYNC_W = 16;

	typedef logic [SYNC_W-1:0] sync_word_t;

	localparam sync_word_t SYNC_RESET = 16'hFEFF;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,   // taking received bytes
		ST_SYNC,   // writing second sync byte to the store
		ST_DRAIN   // streaming the completed frame out
	} scd_state_t;

endpackage

[rtl/scd_if.sv]
// ----------------------------------------------------------------------------
// scd_if
// Valid/ready channels for received bytes and for completed frame bytes.
// ----------------------------------------------------------------------------

// Received byte channel
interface scd_rx_if;
	import scd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Frame byte channel
interface scd_frm_if;
	import scd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic [IDX_W-1:0]  byte_index;
	logic [FLEN_W-1:0] frame_length;
	logic              checksum_good;
	logic              last_byte;

	modport source (
		output valid, output frame_byte, output byte_index, output frame_length,
		output checksum_good, output last_byte, input ready
	);
	modport sink (
		input valid, input frame_byte, input byte_index, input frame_length,
		input checksum_good, input last_byte, output ready
	);
endinterface

[rtl/sync_length_checksum_deframer_core.sv]
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Serial deframer: sync word detection, length-terminated frames held in a
// frame store with a registered read port, inverted-sum checksum, byte-wise frame drain.
// ----------------------------------------------------------------------------
// Output: the first byte of a completed frame is presented in the cycle after the
// closing byte is taken; then one frame byte per cycle while the sink is ready.
// Input: one received byte per cycle while ready is high; input is held off while
// the second sync byte of a sync pair is written to the store, and while a
// completed frame drains through the single read port of the frame store.
// Reset: sync word 0xFEFF, no frame open, previous byte zero; store not cleared.
module sync_length_checksum_deframer_core #(
	parameter int MAX_FRAME = scd_pkg::MAX_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  scd_pkg::sync_word_t cfg_wr_data,
	scd_rx_if.sink              rx,
	scd_frm_if.source           frm
);
	import scd_pkg::*;

	localparam int AW = $clog2(MAX_FRAME);
	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int LW = BYTE_W + 1;

	// Registers
	scd_state_t        state_q, state_nxt;
	sync_word_t        sync_q;
	logic [BYTE_W-1:0] prev_q;
	logic [CW-1:0]     held_q;
	logic [BYTE_W-1:0] sum_q, len_q, ck_q;
	logic              good_q;
	logic [CW-1:0]     drain_n_q;
	logic [AW-1:0]     rd_ptr_q;

	// Frame store
	logic [BYTE_W-1:0] mem [MAX_FRAME];
	logic [BYTE_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [BYTE_W-1:0] mem_wd;

	// Byte decode
	logic              acc, is_sync, append, done, last;
	logic [CW-1:0]     new_held;
	logic [BYTE_W-1:0] sum_nxt, len_nxt, ck_nxt;
	logic [CW+IDX_W-1:0]  idx_ext;
	logic [CW+FLEN_W-1:0] len_ext;

	assign acc      = rx.valid && rx.ready;
	assign is_sync  = ({rx.rx_byte, prev_q} == sync_q);
	assign append   = !is_sync && (held_q >= CW'(SUM_START)) &&
	                  (held_q < CW'(MAX_FRAME));
	assign new_held = held_q + CW'(1);

	// Running header capture and checksum
	always_comb begin
		sum_nxt = sum_q;
		len_nxt = len_q;
		ck_nxt  = ck_q;
		if (held_q >= CW'(SUM_START) && held_q != CW'(SUM_IDX)) begin
			sum_nxt = sum_q + rx.rx_byte;
		end
		if (held_q == CW'(LEN_IDX)) begin
			len_nxt = rx.rx_byte;
		end
		if (held_q == CW'(SUM_IDX)) begin
			ck_nxt = rx.rx_byte;
		end
	end

	assign done = append && (new_held > CW'(SUM_IDX)) &&
	              (LW'(new_held) == ({1'b0, len_nxt} + LW'(LEN_OFFSET)));

	assign last = ((CW'(rd_ptr_q) + CW'(1)) == drain_n_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && is_sync) begin
					state_nxt = ST_SYNC;
				end else if (acc && done) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_SYNC: begin
				state_nxt = ST_IDLE;
			end
			ST_DRAIN: begin
				if (frm.ready && last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs
	always_comb begin
		rx.ready  = 1'b0;
		frm.valid = 1'b0;
		case (state_q)
			ST_IDLE:  rx.ready  = 1'b1;
			ST_DRAIN: frm.valid = 1'b1;
			default: begin
				rx.ready  = 1'b0;
				frm.valid = 1'b0;
			end
		endcase
	end

	// Store access control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = rx.rx_byte;
		if (state_q == ST_SYNC) begin
			mem_we = 1'b1;
			mem_wa = AW'(1);
			mem_wd = prev_q;
		end else if (acc && is_sync) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = prev_q;
		end else if (acc && append) begin
			mem_we = 1'b1;
			mem_wa = held_q[AW-1:0];
			mem_wd = rx.rx_byte;
		end
		mem_re = (acc && done) || (frm.valid && frm.ready && !last);
		mem_ra = acc ? '0 : (rd_ptr_q + AW'(1));
	end

	// Frame store: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sync_q  <= SYNC_RESET;
			prev_q  <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				sync_q <= cfg_wr_data;
			end
			if (acc) begin
				prev_q <= rx.rx_byte;
				if (is_sync) begin
					held_q <= CW'(SUM_START);
				end else if (append) begin
					held_q <= (done || new_held == CW'(MAX_FRAME)) ? '0 : new_held;
				end
			end
		end
	end

	// Header, checksum and drain registers
	always_ff @(posedge clk) begin
		if (acc && is_sync) begin
			sum_q <= '0;
		end else if (acc && append) begin
			sum_q <= sum_nxt;
			len_q <= len_nxt;
			ck_q  <= ck_nxt;
		end
		if (acc && done) begin
			good_q    <= (~sum_nxt == ck_nxt);
			drain_n_q <= new_held;
			rd_ptr_q  <= '0;
		end else if (frm.valid && frm.ready && !last) begin
			rd_ptr_q <= rd_ptr_q + AW'(1);
		end
	end

	// Output transaction payload
	assign idx_ext = {{IDX_W{1'b0}}, CW'(rd_ptr_q)};
	assign len_ext = {{FLEN_W{1'b0}}, drain_n_q};

	assign frm.frame_byte    = rd_data_q;
	assign frm.byte_index    = idx_ext[IDX_W-1:0];
	assign frm.frame_length  = len_ext[FLEN_W-1:0];
	assign frm.checksum_good = good_q;
	assign frm.last_byte     = last;

	// Checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx.ready && frm.valid))
		else $error("input taken while a frame drains");

	a_held_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < CW'(MAX_FRAME))
		else $error("held count reached store depth");

	a_drain_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (CW'(rd_ptr_q) < drain_n_q))
		else $error("drain pointer beyond frame length");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(frm.valid && frm.ready && frm.last_byte) |=> rx.ready)
		else $error("input not reopened after last frame byte");

	a_sync_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYNC) |=> (state_q == ST_IDLE))
		else $error("second sync byte write overran");

endmodule

[sim/sync_length_checksum_deframer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core_tb
// Drives received bytes through the deframer under random source and sink
// gaps. A behavioural copy of the deframer predicts every frame byte. A
// scoreboard process compares each output transaction field by field, in
// order. Short directed frames come first. Random well-formed frames, noise
// and broken frames follow, under several sync words.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core_tb;
	import scd_pkg::*;

	localparam int MAX_FRAME     = MAX_FRAME_DEF;
	localparam int CLK_HALF      = 5;
	localparam int IDLE_PCT      = 26;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic [IDX_W-1:0]  byte_index;
		logic [FLEN_W-1:0] frame_length;
		logic              checksum_good;
		logic              last_byte;
	} frame_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	sync_word_t cfg_wr_data;

	scd_rx_if  rx_ch ();
	scd_frm_if frm_ch ();

	sync_length_checksum_deframer_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx_ch),
		.frm         (frm_ch)
	);

	// Deframer shadow state
	sync_word_t        sync_shadow;
	logic [BYTE_W-1:0] prev_shadow;
	int                held_shadow;
	logic [BYTE_W-1:0] store_shadow [MAX_FRAME];

	frame_beat_t frame_beats_due [$];
	int          err_count = 0;
	int          rx_taken  = 0;
	bit          gaps_off  = 1'b0;

	always #CLK_HALF clk = ~clk;

	// Sink back-pressure
	always @(negedge clk) begin
		frm_ch.ready <= gaps_off || ($urandom_range(99) >= IDLE_PCT);
	end

	// Queue every byte of a completed frame, checksum flag included
	function automatic void queue_frame_beats();
		logic [BYTE_W-1:0] sum;
		logic              good;
		frame_beat_t       beat;
		sum = '0;
		for (int i = SUM_START; i < held_shadow; i++) begin
			if (i != SUM_IDX)
				sum = sum + store_shadow[i];
		end
		good = (~sum == store_shadow[SUM_IDX]);
		for (int i = 0; i < held_shadow; i++) begin
			beat.frame_byte    = store_shadow[i];
			beat.byte_index    = IDX_W'(i);
			beat.frame_length  = FLEN_W'(held_shadow);
			beat.checksum_good = good;
			beat.last_byte     = (i + 1 == held_shadow);
			frame_beats_due    = {frame_beats_due, beat};
		end
	endfunction

	// Advance the shadow deframer by one received byte
	function automatic void deframe_predict(input logic [BYTE_W-1:0] b);
		sync_word_t pair;
		pair = {b, prev_shadow};
		if (pair == sync_shadow) begin
			store_shadow[0] = prev_shadow;
			store_shadow[1] = b;
			held_shadow     = 2;
		end else if (held_shadow >= 2 && held_shadow < MAX_FRAME) begin
			store_shadow[held_shadow] = b;
			held_shadow++;
		end
		if (held_shadow > SUM_IDX && held_shadow <= MAX_FRAME &&
		    int'(store_shadow[LEN_IDX]) + LEN_OFFSET == held_shadow) begin
			queue_frame_beats();
			held_shadow = 0;
		end
		if (held_shadow >= MAX_FRAME)
			held_shadow = 0;
		prev_shadow = b;
	endfunction

	// Scoreboard: compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && frm_ch.valid && frm_ch.ready) begin
			if (frame_beats_due.size() == 0) begin
				$error("unexpected frame byte %0h", frm_ch.frame_byte);
				err_count++;
			end else begin
				want = frame_beats_due.pop_front();
				if (frm_ch.frame_byte !== want.frame_byte) begin
					$error("frame_byte: expected %0h, got %0h",
						want.frame_byte, frm_ch.frame_byte);
					err_count++;
				end
				if (frm_ch.byte_index !== want.byte_index) begin
					$error("byte_index: expected %0d, got %0d",
						want.byte_index, frm_ch.byte_index);
					err_count++;
				end
				if (frm_ch.frame_length !== want.frame_length) begin
					$error("frame_length: expected %0d, got %0d",
						want.frame_length, frm_ch.frame_length);
					err_count++;
				end
				if (frm_ch.checksum_good !== want.checksum_good) begin
					$error("checksum_good: expected %0b, got %0b",
						want.checksum_good, frm_ch.checksum_good);
					err_count++;
				end
				if (frm_ch.last_byte !== want.last_byte) begin
					$error("last_byte: expected %0b, got %0b",
						want.last_byte, frm_ch.last_byte);
					err_count++;
				end
			end
		end
	end

	// One received byte; entered and left at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!gaps_off && $urandom_range(99) < IDLE_PCT) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		deframe_predict(b);
		rx_taken++;
		@(negedge clk);
	endtask

	// Frame opened by the current sync word. An unmatchable length byte
	// runs past the store depth. cut > 0 stops the frame early.
	task automatic send_frame(input logic [BYTE_W-1:0] len_byte, input bit good_sum,
	                          input int cut);
		logic [BYTE_W-1:0] body [MAX_FRAME+2];
		logic [BYTE_W-1:0] sum;
		int                n;
		n = (len_byte >= 1 && int'(len_byte) + LEN_OFFSET <= MAX_FRAME) ?
			int'(len_byte) + LEN_OFFSET : MAX_FRAME + 2;
		if (cut > 0 && cut < n)
			n = cut;
		body[0]       = sync_shadow[7:0];
		body[1]       = sync_shadow[15:8];
		body[LEN_IDX] = len_byte;
		sum           = len_byte;
		for (int i = SUM_START; i < MAX_FRAME + 2; i++) begin
			if (i != LEN_IDX && i != SUM_IDX) begin
				body[i] = BYTE_W'($urandom);
				if (i < int'(len_byte) + LEN_OFFSET)
					sum = sum + body[i];
			end
		end
		body[SUM_IDX] = good_sum ? ~sum : ~sum ^ BYTE_W'($urandom_range(255, 1));
		for (int i = 0; i < n; i++)
			send_byte(body[i]);
	endtask

	// Let the block empty out, then allow for work that yields no output
	task automatic wait_drained();
		int n;
		n = 0;
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (frame_beats_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		if (frame_beats_due.size() != 0) begin
			$error("%0d frame bytes never arrived", frame_beats_due.size());
			err_count++;
			frame_beats_due.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_sync(input sync_word_t w);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sync_shadow = w;
		@(negedge clk);
	endtask

	// Mostly well-formed frames, some noise, broken and unmatchable frames
	task automatic random_traffic(input int n_items);
		int          target;
		int          r;
		logic [7:0]  len_byte;
		target = rx_taken + n_items;
		while (rx_taken < target) begin
			r = int'($urandom_range(99));
			if (r < 55)
				len_byte = BYTE_W'($urandom_range(4, 1));
			else if (r < 70)
				len_byte = BYTE_W'($urandom_range(MAX_FRAME - LEN_OFFSET, 5));
			else if (r < 75)
				len_byte = BYTE_W'(MAX_FRAME - LEN_OFFSET);
			else if (r < 80)
				len_byte = ($urandom_range(1) == 0) ? 8'd0 :
					BYTE_W'($urandom_range(255, MAX_FRAME - LEN_OFFSET + 1));
			else
				len_byte = BYTE_W'($urandom_range(MAX_FRAME - LEN_OFFSET, 1));
			if (r < 80)
				send_frame(len_byte, $urandom_range(99) < 80, 0);
			else if (r < 90)
				send_byte(BYTE_W'($urandom));
			else
				send_frame(len_byte, 1'b1, int'($urandom_range(int'(len_byte) + 3, 2)));
		end
	endtask

	// Bytes with no frame open, at both extremes
	task automatic test_idle_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	// Shortest frame with a good checksum, under the reset sync word
	task automatic test_min_frame();
		send_frame(8'd1, 1'b1, 0);
	endtask

	// A bad checksum still drains the frame, flagged
	task automatic test_bad_checksum();
		send_frame(8'd1, 1'b0, 0);
	endtask

	// Sync pattern inside an open frame restarts it
	task automatic test_resync();
		send_frame(8'd3, 1'b1, 4);
		send_frame(8'd1, 1'b1, 0);
	endtask

	// Sync word extremes and a random one
	task automatic test_sync_words();
		write_sync(16'h0000);
		random_traffic(55);
		write_sync(16'hFFFF);
		random_traffic(55);
		write_sync(sync_word_t'($urandom));
		random_traffic(55);
	endtask

	// Long stretch with neither side idling
	task automatic test_no_gaps();
		write_sync(SYNC_RESET);
		gaps_off = 1'b1;
		random_traffic(70);
		gaps_off = 1'b0;
	endtask

	// Sender holds off until every frame byte has come out
	task automatic test_sender_pause();
		for (int i = 0; i < 3; i++) begin
			send_frame(BYTE_W'($urandom_range(MAX_FRAME - LEN_OFFSET, 1)), 1'b1, 0);
			wait_drained();
		end
		write_sync(sync_word_t'($urandom));
		random_traffic(70);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		frm_ch.ready  = 1'b0;
		sync_shadow   = SYNC_RESET;
		prev_shadow   = '0;
		held_shadow   = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_noise();
		test_min_frame();
		test_bad_checksum();
		test_resync();
		test_sync_words();
		test_no_gaps();
		test_sender_pause();
		wait_drained();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sync_length_checksum_deframer_core.f]
rtl/scd_pkg.sv
rtl/scd_if.sv
rtl/sync_length_checksum_deframer_core.sv
sim/sync_length_checksum_deframer_core_tb.sv
